/* hdl/rbfk_pkg.sv */
// shared types, constants and exp table for the rbf kernel block
package rbfk_pkg;

    localparam int unsigned ElemW   = 16;
    localparam int unsigned SumW    = 48;
    localparam int unsigned RegW    = 16;
    localparam int unsigned QuoW    = 22;
    localparam int unsigned TW      = 23;
    localparam int unsigned MantW   = 17;
    localparam int unsigned KW      = 7;
    localparam int unsigned ValW    = 24;
    localparam int unsigned StepW   = 5;
    localparam int unsigned MaxLen  = 1024;

    localparam logic [SumW-1:0]  SumMax   = {SumW{1'b1}};
    localparam logic [30:0]      Log2eQ30 = 31'd1549082005;
    localparam logic [QuoW-1:0]  QClamp   = 22'h200000;
    localparam logic [RegW-1:0]  LsReset  = 16'd256;
    localparam logic [RegW-1:0]  AmpReset = 16'd256;
    localparam logic [KW-1:0]    KMax     = 7'd32;

    // register indexes
    localparam logic CfgLengthScale = 1'b0;
    localparam logic CfgAmplitude   = 1'b1;

    typedef enum logic [2:0] {
        S_ACC,
        S_DIV,
        S_EXP,
        S_MANT,
        S_SCALE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic acc_en;
        logic div_step;
        logic exp_en;
        logic mant_en;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } t_stat;

    // 2^(-i/16) in Q16
    function automatic logic [MantW-1:0] exp2_neg(input logic [4:0] i);
        logic [MantW-1:0] v;
        case (i)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

/* hdl/rbfk_ctrl.sv */
// controller state machine for the rbf kernel block
module rbfk_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_fire,
    input  logic           i_in_last,
    input  rbfk_pkg::t_stat i_stat,
    output logic           o_ready,
    output rbfk_pkg::t_cmd o_cmd
);
    import rbfk_pkg::*;

    t_state          r_state, n_state;
    logic [StepW-1:0] r_cnt, n_cnt;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_ACC: begin
                o_ready      = 1'b1;
                o_cmd.acc_en = i_in_fire;
                if (i_in_fire && i_in_last) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == StepW'(QuoW - 1)) begin
                    n_state = S_EXP;
                end
            end
            S_EXP: begin
                o_cmd.exp_en = 1'b1;
                n_state      = S_MANT;
            end
            S_MANT: begin
                o_cmd.mant_en = 1'b1;
                n_state       = S_SCALE;
            end
            S_SCALE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

endmodule

/* hdl/rbfk_datapath.sv */
// accumulator, divider, exp approximation and output register
module rbfk_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rbfk_pkg::t_cmd                i_cmd,
    input  logic signed [rbfk_pkg::ElemW-1:0] i_first_elem,
    input  logic signed [rbfk_pkg::ElemW-1:0] i_second_elem,
    input  logic                          i_last,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [rbfk_pkg::RegW-1:0]     i_cfg_data,
    input  logic                          i_out_ready,
    output rbfk_pkg::t_stat               o_stat,
    output logic                          o_out_valid,
    output logic [rbfk_pkg::ValW-1:0]     o_kernel_value,
    output logic                          o_clamped
);
    import rbfk_pkg::*;

    logic [RegW-1:0]  r_ls, r_amp;
    logic [SumW-1:0]  r_sum;
    logic             r_sat;
    logic [31:0]      r_rem;
    logic [QuoW-1:0]  r_nlow;
    logic [QuoW-1:0]  r_quo;
    logic             r_ovf;
    logic             r_flag;
    logic [TW-1:0]    r_t;
    logic [MantW-1:0] r_m;
    logic [KW-1:0]    r_k;
    logic             r_valid;
    logic [ValW-1:0]  r_val;
    logic             r_clamp;

    logic signed [ElemW:0] diff;
    logic [ElemW-1:0]      mag;
    logic [31:0]           sq;
    logic [SumW:0]         sum_wide;
    logic                  sat_now;
    logic [SumW-1:0]       n_sum;
    logic [31:0]           r2;
    logic [32:0]           trial;
    logic                  qbit;
    logic [31:0]           rem_next;
    logic [QuoW-1:0]       q_use;
    logic [52:0]           t_prod;
    logic [52:0]           t_rnd;
    logic [4:0]            idx;
    logic [MantW-1:0]      t_hi, t_lo;
    logic [ElemW-1:0]      delta;
    logic [27:0]           interp;
    logic [32:0]           prod;
    logic [40:0]           prod_rnd;
    logic [40:0]           shifted;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ls  <= LsReset;
            r_amp <= AmpReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgLengthScale: r_ls  <= i_cfg_data;
                CfgAmplitude:   r_amp <= i_cfg_data;
                default:        r_ls  <= r_ls;
            endcase
        end
    end

    // squared difference and saturating sum
    always_comb begin
        diff     = $signed({i_second_elem[ElemW-1], i_second_elem})
                 - $signed({i_first_elem[ElemW-1], i_first_elem});
        mag      = diff[ElemW] ? ElemW'(-diff) : diff[ElemW-1:0];
        sq       = mag * mag;
        sum_wide = {1'b0, r_sum} + {{(SumW-31){1'b0}}, sq};
        sat_now  = sum_wide[SumW];
        n_sum    = sat_now ? SumMax : sum_wide[SumW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_sat <= 1'b0;
        end else if (i_cmd.acc_en) begin
            if (i_last) begin
                r_sum <= '0;
                r_sat <= 1'b0;
            end else begin
                r_sum <= n_sum;
                r_sat <= r_sat | sat_now;
            end
        end
    end

    // restoring divide of sum*2^15 by r^2, one quotient bit a cycle
    always_comb begin
        r2       = (r_ls == '0) ? 32'd1 : r_ls * r_ls;
        trial    = {r_rem, r_nlow[QuoW-1]};
        qbit     = (trial >= {1'b0, r2});
        rem_next = qbit ? 32'(trial - {1'b0, r2}) : trial[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_en && i_last) begin
            r_rem  <= n_sum[SumW-1:7] >= {9'd0, r2} ? '0 : n_sum[38:7];
            r_ovf  <= (n_sum[SumW-1:7] >= {9'd0, r2});
            r_nlow <= {n_sum[6:0], 15'd0};
            r_quo  <= '0;
            r_flag <= r_sat | sat_now;
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_next;
            r_nlow <= {r_nlow[QuoW-2:0], 1'b0};
            r_quo  <= {r_quo[QuoW-2:0], qbit};
        end
    end

    // exponent t = q * log2(e), rounded
    always_comb begin
        q_use  = (r_ovf || r_quo > QClamp) ? QClamp : r_quo;
        t_prod = q_use * Log2eQ30;
        t_rnd  = t_prod + 53'(1 << 29);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exp_en) begin
            r_t <= t_rnd[52:30];
        end
    end

    // table lookup with linear interpolation
    always_comb begin
        idx    = {1'b0, r_t[15:12]};
        t_hi   = exp2_neg(idx);
        t_lo   = exp2_neg(idx + 5'd1);
        delta  = 16'(t_hi - t_lo);
        interp = delta * r_t[11:0] + 28'd2048;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mant_en) begin
            r_m <= t_hi - MantW'(interp[27:12]);
            r_k <= r_t[TW-1:16];
        end
    end

    // amplitude scale and rounding shift by 8+k
    always_comb begin
        prod     = r_amp * r_m;
        prod_rnd = {8'd0, prod} + (41'd1 << (r_k[5:0] + 6'd7));
        shifted  = prod_rnd >> (r_k[5:0] + 6'd8);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_val   <= (r_k > KMax) ? '0 : shifted[ValW-1:0];
            r_clamp <= r_flag;
        end
    end

    assign o_stat.out_busy = r_valid && !i_out_ready;
    assign o_out_valid     = r_valid;
    assign o_kernel_value  = r_val;
    assign o_clamped       = r_clamp;

endmodule

/* hdl/rbf_kernel_pair.sv */
// Gaussian rbf kernel between two streamed vectors. One element pair is taken
// per cycle while a vector accumulates; the pair marked last starts a restoring
// divide of the distance sum by 2*r^2, then the exponent multiply, the table
// interpolation and the amplitude scale, before the result word is offered.
// The result waits in an output register; the input side can take the next vector meanwhile.
// The user must write length scale (index 0) and amplitude (index 1) only
// while idle; the block itself does not enforce this.
module rbf_kernel_pair (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // first_elem[15:0], second_elem[31:16]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // kernel_value[23:0]
    output logic        m_axis_tuser,   // clamped
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import rbfk_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  ready;

    assign s_axis_tready = ready;

    // controller
    rbfk_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (s_axis_tvalid && ready),
        .i_in_last (s_axis_tlast),
        .i_stat    (stat),
        .o_ready   (ready),
        .o_cmd     (cmd)
    );

    // datapath
    rbfk_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_first_elem   (s_axis_tdata[15:0]),
        .i_second_elem  (s_axis_tdata[31:16]),
        .i_last         (s_axis_tlast),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (m_axis_tready),
        .o_stat         (stat),
        .o_out_valid    (m_axis_tvalid),
        .o_kernel_value (m_axis_tdata),
        .o_clamped      (m_axis_tuser)
    );

endmodule

/* hdl/rbfk_checker.sv */
// port-level checks for the rbf kernel block
module rbfk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    // reset leaves no word on the output
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a pair that is not last never produces a word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid)
        |=> !m_axis_tvalid)
        else $error("word without last pair");

    // the last pair starts the divide and input stalls
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken during divide");

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output word dropped or changed");

endmodule

bind rbf_kernel_pair rbfk_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/rbf_kernel_checker.sv */
// checker for the rbf kernel block: tracks registers, predicts kernel words, compares
module rbf_kernel_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,    // first_elem[15:0], second_elem[31:16]
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,   // kernel_value[23:0]
    input  logic        i_out_user,   // clamped
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rbfk_pkg::*;

    typedef struct packed {
        logic [23:0] value;
        logic        clamped;
    } t_kernel_word;

    // 2^(-i/16) in Q16
    localparam int unsigned Exp2Tab [17] = '{
        65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
        44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
    };

    t_kernel_word     kernel_q[$];
    logic [SumW-1:0]  dist_acc;
    logic             acc_sat;
    logic [15:0]      scale_r;
    logic [15:0]      amp_d;

    // amplitude * exp(-sum / (2 r^2)) as unsigned Q8.16
    function automatic logic [23:0] gauss_of(logic [SumW-1:0] sum, logic [15:0] r,
                                             logic [15:0] d);
        longint unsigned r2, q16, t16, prod, m, hi, lo;
        int unsigned k, idx, g;
        r2 = longint'(r) * longint'(r);
        if (r2 == 0)
            r2 = 1;
        q16 = (longint'(sum) << 15) / r2;
        if (q16 > (64'd32 << 16))
            q16 = 64'd32 << 16;
        t16 = (q16 * 64'd1549082005 + (64'd1 << 29)) >> 30;
        k = int'(t16 >> 16);
        if (k > 32)
            return '0;
        idx = int'((t16 >> 12) & 64'hF);
        g = int'(t16 & 64'hFFF);
        hi = Exp2Tab[idx];
        lo = Exp2Tab[idx + 1];
        m = hi - (((hi - lo) * g + 2048) >> 12);
        prod = longint'(d) * m;
        return 24'((prod + (64'd1 << (7 + k))) >> (8 + k));
    endfunction

    always @(posedge i_clk) begin
        logic signed [16:0] diff;
        logic [15:0]        mag;
        logic [31:0]        sq;
        logic [SumW:0]      nsum;
        logic               sat_step;
        t_kernel_word       exp_w;
        if (!i_rst_n) begin
            dist_acc <= '0;
            acc_sat  <= 1'b0;
            scale_r  <= LsReset;
            amp_d    <= AmpReset;
            kernel_q.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                if (i_cfg_idx == CfgLengthScale)
                    scale_r <= i_cfg_data;
                else
                    amp_d <= i_cfg_data;
            end
            // accumulate one element pair, emit on last
            if (i_in_valid && i_in_ready) begin
                diff = $signed({i_in_data[31], i_in_data[31:16]})
                     - $signed({i_in_data[15], i_in_data[15:0]});
                mag      = diff[16] ? 16'(-diff) : diff[15:0];
                sq       = mag * mag;
                nsum     = {1'b0, dist_acc} + {{(SumW-31){1'b0}}, sq};
                sat_step = nsum[SumW];
                if (sat_step)
                    nsum = {1'b0, SumMax};
                if (i_in_last) begin
                    exp_w.value   = gauss_of(nsum[SumW-1:0], scale_r, amp_d);
                    exp_w.clamped = acc_sat || sat_step;
                    kernel_q.push_back(exp_w);
                    dist_acc <= '0;
                    acc_sat  <= 1'b0;
                end else begin
                    dist_acc <= nsum[SumW-1:0];
                    acc_sat  <= acc_sat || sat_step;
                end
            end
            // compare result words with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (kernel_q.size() == 0) begin
                    $display("%0t: unexpected word value=%h clamped=%b",
                             $realtime, i_out_data, i_out_user);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_w = kernel_q.pop_front();
                    if (exp_w.value !== i_out_data || exp_w.clamped !== i_out_user) begin
                        $display("%0t: mismatch expected value=%h clamped=%b actual value=%h clamped=%b",
                                 $realtime, exp_w.value, exp_w.clamped, i_out_data, i_out_user);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= kernel_q.size();
        end
    end

endmodule

/* tb/tb_rbf_kernel_pair.sv */
// testbench top for the rbf kernel block: stimulus, receiver stalls and verdict
module tb_rbf_kernel_pair;
    timeunit 1ns;
    timeprecision 1ps;
    import rbfk_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CfgLengthScale;
    logic [15:0] i_cfg_data = '0;
    int          errors;
    int          pending;
    bit          hold_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rbf_kernel_pair u_dut (.*);

    rbf_kernel_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_last(s_axis_tlast),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // offer one word and wait for it to be taken, optional gap afterwards
    task automatic send_pair(logic [15:0] a, logic [15:0] b, logic lst, int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drain, let the back stage settle, then write a register
    task automatic write_reg(logic idx, logic [15:0] val);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: random stalls, free-running stretches, one long hold-off
    initial begin
        int mode;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 3);
            if (!hold_done && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                repeat ($urandom_range(20, 120)) begin
                    case (mode)
                        0: m_axis_tready <= 1'b1;
                        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                        default: m_axis_tready <= ($urandom_range(0, 1) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // stimulus
    initial begin
        int len, burst;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes at reset settings: largest distance, zero distance, mixed
        send_pair(16'h8000, 16'h7FFF, 1'b1, 0);
        send_pair(16'h7FFF, 16'h8000, 1'b1, 0);
        send_pair(16'h1234, 16'h1234, 1'b1, 0);
        send_pair(16'h0100, 16'h0000, 1'b0, 0);
        send_pair(16'hFF00, 16'h0000, 1'b1, 2);
        send_pair(16'h0000, 16'h0080, 1'b1, 0);
        write_reg(CfgAmplitude, 16'hFFFF);
        write_reg(CfgLengthScale, 16'hFFFF);
        send_pair(16'h0000, 16'h0000, 1'b1, 0);
        send_pair(16'h8000, 16'h7FFF, 1'b0, 0);
        send_pair(16'h8000, 16'h7FFF, 1'b1, 0);
        write_reg(CfgAmplitude, 16'h0000);
        send_pair(16'h0000, 16'h0001, 1'b1, 0);
        write_reg(CfgAmplitude, 16'h0100);
        // zero length scale is treated as the smallest r^2
        write_reg(CfgLengthScale, 16'h0000);
        send_pair(16'h0000, 16'h0000, 1'b1, 0);
        send_pair(16'h0000, 16'h0001, 1'b1, 0);
        write_reg(CfgLengthScale, 16'h0001);
        send_pair(16'h0000, 16'h0001, 1'b1, 0);
        // long vector of largest distances at the widest length scale
        write_reg(CfgLengthScale, 16'hFFFF);
        for (int n = 0; n < 40; n++)
            send_pair(16'h8000, 16'h7FFF, n == 39, 0);
        send_pair(16'h0001, 16'h0002, 1'b1, 0);

        // random vectors over several register settings
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_reg(CfgLengthScale, 16'h0100);
                1: write_reg(CfgLengthScale, 16'($urandom_range(1, 65535)));
                2: write_reg(CfgAmplitude, 16'($urandom));
                3: write_reg(CfgLengthScale, 16'($urandom_range(16, 4096)));
                4: write_reg(CfgAmplitude, 16'hFFFF);
                5: write_reg(CfgLengthScale, 16'h0001);
                6: write_reg(CfgLengthScale, 16'($urandom_range(1024, 65535)));
                default: write_reg(CfgAmplitude, 16'($urandom_range(1, 1024)));
            endcase
            burst = 0;
            while (burst < 58) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                 : $urandom_range(1, 6);
                for (int e = 0; e < len; e++) begin
                    send_pair(rand_elem(), rand_elem(), e == len - 1,
                              ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0);
                    burst++;
                end
                // sender pause until all kernel words are back
                if ($urandom_range(0, 7) == 0) begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0)
                        @(posedge i_clk);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // timeout
    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
